// ===== design/oaid_pkg.sv =====
// ----------------------------------------------------------------------------
// oaid_pkg: shared types and constants of the ordered array block
// Widths, operation and status codes, controller state and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package oaid_pkg;

    localparam int CAPACITY  = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 6;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 6;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic dump_start;
        logic dump_step;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic dump_last;
    } dp_stat_t;

endpackage

// ===== design/oaid_ctrl.sv =====
// ----------------------------------------------------------------------------
// oaid_ctrl: controller of the ordered array block
// Sequences single-result operations and dumps of one result per held
// word, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module oaid_ctrl
    import oaid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    output logic              out_valid,
    input  logic              out_ready,
    output dp_cmd_t           cmd,
    input  dp_stat_t          stat
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        accept;

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        in_ready       = (state_reg == S_IDLE) && out_free;
        accept         = in_valid && in_ready;
        cmd            = '0;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FN_DUMP && !stat.empty)
                    begin
                        cmd.dump_start = 1'b1;
                        state_next     = S_DUMP;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    cmd.dump_step = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.exec || cmd.dump_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/oaid_dp.sv =====
// ----------------------------------------------------------------------------
// oaid_dp: datapath of the ordered array block
// Chain of shifting word cells with a count, operation checks, dump index
// and the output result register.
// ----------------------------------------------------------------------------
module oaid_dp
    import oaid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [FUNC_W-1:0]        func,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value_in,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] value_out,
    output logic [POS_W-1:0]         out_position,
    output logic [CNT_OUT_W-1:0]     count_out,
    output logic                     last
);

    logic signed [DATA_W-1:0] cell_reg  [CAPACITY];
    logic signed [DATA_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]         count_reg, count_next, count_upd;
    logic [IDX_W-1:0]         dump_idx_reg, dump_idx_next;

    logic [STAT_W-1:0]        status_reg, status_next;
    logic signed [DATA_W-1:0] value_out_reg, value_out_next;
    logic [POS_W-1:0]         out_position_reg, out_position_next;
    logic [CNT_OUT_W-1:0]     count_out_reg, count_out_next;
    logic                     last_reg, last_next;

    logic [CMP_W-1:0] cnt_ext, pos_ext;
    logic             is_empty, bad_pos, is_full;
    logic             do_ins, do_del, do_app, do_clr;
    logic [STAT_W-1:0] op_stat;

    always_comb
    begin
        cnt_ext  = CMP_W'(count_reg);
        pos_ext  = CMP_W'(position);
        is_empty = (count_reg == '0);
        bad_pos  = (position == '0) || (pos_ext > cnt_ext);
        is_full  = (cnt_ext >= CMP_W'(CAPACITY));
        op_stat  = STAT_OK;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_app   = 1'b0;
        do_clr   = 1'b0;
        case (func)
            FN_INSERT:
            begin
                if (is_empty)
                    op_stat = STAT_EMPTY;
                else if (bad_pos)
                    op_stat = STAT_RANGE;
                else if (is_full)
                    op_stat = STAT_FULL;
                else
                    do_ins = 1'b1;
            end
            FN_DELETE:
            begin
                if (is_empty)
                    op_stat = STAT_EMPTY;
                else if (bad_pos)
                    op_stat = STAT_RANGE;
                else
                    do_del = 1'b1;
            end
            FN_DUMP:
            begin
                if (is_empty)
                    op_stat = STAT_EMPTY;
            end
            FN_APPEND:
            begin
                if (is_full)
                    op_stat = STAT_FULL;
                else
                    do_app = 1'b1;
            end
            FN_CLEAR:
            begin
                do_clr = 1'b1;
            end
            default:
            begin
                op_stat = STAT_OK;
            end
        endcase

        if (do_ins || do_app)
            count_upd = count_reg + CNT_W'(1);
        else if (do_del)
            count_upd = count_reg - CNT_W'(1);
        else if (do_clr)
            count_upd = '0;
        else
            count_upd = count_reg;
        count_next = cmd.exec ? count_upd : count_reg;

        // shift the chain: each cell looks only at its neighbors and the input word
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.exec)
            begin
                if (do_ins)
                begin
                    if (CMP_W'(i) + CMP_W'(1) == pos_ext)
                        cell_next[i] = value_in;
                    else if (CMP_W'(i) >= pos_ext && i > 0)
                        cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                end
                else if (do_del)
                begin
                    if (CMP_W'(i) + CMP_W'(1) >= pos_ext && i < CAPACITY - 1)
                        cell_next[i] = cell_reg[(i == CAPACITY - 1) ? i : i + 1];
                end
                else if (do_app)
                begin
                    if (CMP_W'(i) == cnt_ext)
                        cell_next[i] = value_in;
                end
            end
        end

        stat.empty     = is_empty;
        stat.dump_last = ((CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg);

        if (cmd.dump_start)
            dump_idx_next = '0;
        else if (cmd.dump_step)
            dump_idx_next = dump_idx_reg + IDX_W'(1);
        else
            dump_idx_next = dump_idx_reg;

        status_next       = status_reg;
        value_out_next    = value_out_reg;
        out_position_next = out_position_reg;
        count_out_next    = count_out_reg;
        last_next         = last_reg;
        if (cmd.exec)
        begin
            status_next       = op_stat;
            value_out_next    = '0;
            out_position_next = '0;
            count_out_next    = CNT_OUT_W'(count_upd);
            last_next         = 1'b1;
        end
        else if (cmd.dump_step)
        begin
            status_next       = STAT_OK;
            value_out_next    = cell_reg[dump_idx_reg];
            out_position_next = POS_W'(dump_idx_reg) + POS_W'(1);
            count_out_next    = CNT_OUT_W'(count_reg);
            last_next         = stat.dump_last;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        status_reg       <= status_next;
        value_out_reg    <= value_out_next;
        out_position_reg <= out_position_next;
        count_out_reg    <= count_out_next;
        last_reg         <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dump_idx_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
        end
    end

    assign status       = status_reg;
    assign value_out    = value_out_reg;
    assign out_position = out_position_reg;
    assign count_out    = count_out_reg;
    assign last         = last_reg;

endmodule

// ===== design/ordered_array_insert_delete.sv =====
// ----------------------------------------------------------------------------
// ordered_array_insert_delete: ordered list of signed words
// Holds up to 32 words in a chain of shifting cells. Insert, delete, append,
// clear, unknown codes and a dump of an empty list each give one result
// transaction; any other dump first starts the read and then gives one
// transaction per held word, one per cycle while the output is not stalled,
// and the input waits until the last one is loaded. A new transaction is
// taken while the previous result is being taken at the output. No clearing
// pass after reset.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete
    import oaid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] value_out,
    output logic [POS_W-1:0]         out_position,
    output logic [CNT_OUT_W-1:0]     count_out,
    output logic                     last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    oaid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    oaid_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (func),
        .position     (position),
        .value_in     (value_in),
        .cmd          (cmd),
        .stat         (stat),
        .status       (status),
        .value_out    (value_out),
        .out_position (out_position),
        .count_out    (count_out),
        .last         (last)
    );

endmodule

// ===== design/oaid_checker.sv =====
// ----------------------------------------------------------------------------
// oaid_checker: port checks of the ordered array block
// Watches the top level ports for result hold under stall and field rules.
// ----------------------------------------------------------------------------
module oaid_checker
    import oaid_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [FUNC_W-1:0]        func,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [STAT_W-1:0]        status,
    input logic signed [DATA_W-1:0] value_out,
    input logic [POS_W-1:0]         out_position,
    input logic [CNT_OUT_W-1:0]     count_out,
    input logic                     last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(last))
        else $error("result changed while stalled");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FN_CLEAR |=>
        out_valid && last && count_out == '0 && status == STAT_OK)
        else $error("clear gave a wrong result");

    a_refused_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> value_out == '0 && out_position == '0 && last)
        else $error("refused result carries data");

    a_dump_middle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == STAT_OK && out_position != '0 && !in_ready)
        else $error("dump transaction malformed");

endmodule

bind ordered_array_insert_delete oaid_checker u_oaid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .value_out    (value_out),
    .out_position (out_position),
    .count_out    (count_out),
    .last         (last)
);

// ===== sim/ordered_array_insert_delete_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_tb: self-checking bench for the ordered list
// Sends insert, delete, append, clear, dump and spare operation codes over
// the valid/ready input and predicts every result transaction with a local
// list model. Covers refusals on empty and full lists, out-of-range
// positions, long dumps, sustained output back-pressure and random traffic
// under three idling profiles.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_tb;
    import oaid_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;
    localparam logic [POS_W-1:0]  POS_TOP    = 6'd63;
    localparam logic [DATA_W-1:0] WORD_MIN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX   = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] WORD_ONES  = 32'hffff_ffff;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [DATA_W-1:0]    value;
        logic [POS_W-1:0]     pos;
        logic [CNT_OUT_W-1:0] cnt;
        logic                 last;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
    logic                     out_valid;
    logic                     out_ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value_out;
    logic [POS_W-1:0]         out_position;
    logic [CNT_OUT_W-1:0]     count_out;
    logic                     last;

    logic [DATA_W-1:0] list_words [CAPACITY];
    int                list_count;
    list_result_t      pending_results [$];

    int send_idle_pct;
    int rx_idle_pct;
    int hold_len;
    int hold_seq;

    int errors;
    int n_sent;
    int n_checked;
    int n_dumps;
    int n_full;

    ordered_array_insert_delete dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .position     (position),
        .value_in     (value_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_out    (value_out),
        .out_position (out_position),
        .count_out    (count_out),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: %s mismatch at %0t: got %0h, want %0h", what, $time, got, want);
        errors++;
    endtask

    task automatic push_result(input logic [STAT_W-1:0] st, input logic [DATA_W-1:0] v,
                               input int p, input logic lst);
        list_result_t r;
        r.status = st;
        r.value  = v;
        r.pos    = POS_W'(p);
        r.cnt    = CNT_OUT_W'(list_count);
        r.last   = lst;
        pending_results.push_back(r);
    endtask

    task automatic apply_list_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                                 input logic [DATA_W-1:0] v);
        logic [STAT_W-1:0] st;
        int                pos_i;
        int                i;
        st    = STAT_OK;
        pos_i = int'(p);
        case (f)
            FN_INSERT:
            begin
                if (list_count == 0)
                    st = STAT_EMPTY;
                else if (pos_i == 0 || pos_i > list_count)
                    st = STAT_RANGE;
                else if (list_count >= CAPACITY)
                    st = STAT_FULL;
                else
                begin
                    for (i = list_count; i >= pos_i; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos_i-1] = v;
                    list_count++;
                end
            end
            FN_DELETE:
            begin
                if (list_count == 0)
                    st = STAT_EMPTY;
                else if (pos_i == 0 || pos_i > list_count)
                    st = STAT_RANGE;
                else
                begin
                    for (i = pos_i - 1; i + 1 < list_count; i++)
                        list_words[i] = list_words[i+1];
                    list_count--;
                end
            end
            FN_DUMP:
            begin
                n_dumps++;
                if (list_count == 0)
                    push_result(STAT_EMPTY, '0, 0, 1'b1);
                else
                    for (i = 0; i < list_count; i++)
                        push_result(STAT_OK, list_words[i], i + 1, i + 1 == list_count);
                return;
            end
            FN_APPEND:
            begin
                if (list_count >= CAPACITY)
                    st = STAT_FULL;
                else
                begin
                    list_words[list_count] = v;
                    list_count++;
                end
            end
            FN_CLEAR:
                list_count = 0;
            default:
                ;
        endcase
        if (st == STAT_FULL)
            n_full++;
        push_result(st, '0, 0, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            n_sent++;
            apply_list_op(func, position, value_in);
        end
    end

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", {30'd0, status}, '0);
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (status !== want.status)
                    report_mismatch("status", {30'd0, status}, {30'd0, want.status});
                if (value_out !== want.value)
                    report_mismatch("value_out", value_out, want.value);
                if (out_position !== want.pos)
                    report_mismatch("out_position", {26'd0, out_position}, {26'd0, want.pos});
                if (count_out !== want.cnt)
                    report_mismatch("count_out", {26'd0, count_out}, {26'd0, want.cnt});
                if (last !== want.last)
                    report_mismatch("last", {31'd0, last}, {31'd0, want.last});
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq  = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                           input logic [DATA_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        position <= p;
        value_in <= v;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_ops();
        send_op(FN_INSERT, 6'd1, WORD_MAX);
        send_op(FN_DELETE, 6'd1, '0);
        send_op(FN_DUMP, '0, '0);
        send_op(FN_SPARE_A, 6'd1, WORD_ONES);
        send_op(FN_SPARE_B, POS_TOP, '0);
        send_op(FN_APPEND, '0, WORD_MIN);
        send_op(FN_APPEND, POS_TOP, WORD_MAX);
        send_op(FN_APPEND, '0, '0);
        send_op(FN_APPEND, '0, WORD_ONES);
        send_op(FN_INSERT, '0, 32'h1234_5678);
        send_op(FN_INSERT, POS_TOP, 32'h1234_5678);
        send_op(FN_INSERT, 6'd5, 32'h1234_5678);
        send_op(FN_INSERT, 6'd4, 32'h5555_aaaa);
        send_op(FN_INSERT, 6'd1, 32'haaaa_5555);
        send_op(FN_DELETE, '0, '0);
        send_op(FN_DELETE, POS_TOP, '0);
        send_op(FN_DELETE, 6'd6, '0);
        send_op(FN_DELETE, 6'd1, '0);
        send_op(FN_DUMP, '0, '0);
        send_op(FN_CLEAR, '0, '0);
        send_op(FN_DUMP, '0, '0);
        send_op(FN_SPARE_C, POS_TOP, WORD_ONES);
    endtask

    task automatic test_full_list();
        send_op(FN_CLEAR, '0, '0);
        while (list_count < CAPACITY)
            send_op(FN_APPEND, '0, pick_word());
        send_op(FN_DUMP, '0, '0);
        send_op(FN_APPEND, '0, pick_word());
        send_op(FN_INSERT, 6'd1, pick_word());
        send_op(FN_INSERT, POS_W'(CAPACITY), pick_word());
        send_op(FN_INSERT, POS_W'(CAPACITY + 1), pick_word());
        send_op(FN_DELETE, POS_W'(CAPACITY), '0);
        send_op(FN_DELETE, 6'd1, '0);
        send_op(FN_INSERT, 6'd1, pick_word());
        send_op(FN_APPEND, '0, pick_word());
        send_op(FN_DUMP, '0, '0);
    endtask

    task automatic test_back_pressure();
        hold_len = 150;
        hold_seq++;
        for (int k = 0; k < 12; k++)
        begin
            if (k % 4 == 3)
                send_op(FN_DUMP, '0, '0);
            else
                send_op(FN_APPEND, '0, pick_word());
        end
        wait_all_results();
    endtask

    task automatic send_random_op();
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        int                r;
        r = $urandom_range(0, 99);
        p = '0;
        if (list_count == 0 && r < 70)
            f = FN_APPEND;
        else if (r < 30)
        begin
            f = FN_INSERT;
            p = POS_W'($urandom_range(1, (list_count > 0) ? list_count : 1));
        end
        else if (r < 50)
        begin
            f = FN_DELETE;
            p = POS_W'($urandom_range(1, (list_count > 0) ? list_count : 1));
        end
        else if (r < 65)
            f = FN_APPEND;
        else if (r < 72)
            f = FN_DUMP;
        else if (r < 74)
            f = FN_CLEAR;
        else if (r < 86)
        begin
            f = ($urandom_range(0, 1) != 0) ? FN_INSERT : FN_DELETE;
            if ($urandom_range(0, 2) == 0)
                p = '0;
            else
                p = POS_W'($urandom_range(list_count + 1, POS_TOP));
        end
        else if (r < 92)
        begin
            f = FUNC_W'($urandom_range(FN_SPARE_A, FN_SPARE_C));
            p = POS_W'($urandom);
        end
        else
        begin
            f = FUNC_W'($urandom);
            p = POS_W'($urandom);
        end
        send_op(f, p, pick_word());
    endtask

    task automatic test_random_ops(input int n_ops);
        for (int k = 0; k < n_ops; k++)
            send_random_op();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = '0;
        position      = '0;
        value_in      = '0;
        list_count    = 0;
        send_idle_pct = 0;
        rx_idle_pct   = 0;
        hold_len      = 0;
        hold_seq      = 0;
        errors        = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_dumps       = 0;
        n_full        = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 8;
        rx_idle_pct   = 65;
        test_directed_ops();
        test_full_list();
        test_random_ops(35);
        wait_all_results();

        send_idle_pct = 65;
        rx_idle_pct   = 8;
        test_back_pressure();
        test_random_ops(35);
        wait_all_results();

        send_idle_pct = 0;
        rx_idle_pct   = 0;
        test_random_ops(35);
        wait_all_results();
        repeat (10) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch("leftover expectations", pending_results.size(), '0);
        $display("tb: %0d transactions in, %0d results checked", n_sent, n_checked);
        $display("tb: %0d dumps, %0d full-list refusals", n_dumps, n_full);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
